### hdl/rbd_pkg.sv
// Package for the ring buffer deque: operation and status codes, the
// per-operation result record and fixed field widths.
// No dependencies.
`default_nettype none

package rbd_pkg;

  localparam int CAP_W   = 5;
  localparam int COUNT_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_REAR  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_REAR   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // Everything known about an operation at issue time; popped data follows
  // from the registered RAM read.
  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   count;
    logic                 empty;
    logic                 pop_ok;
  } result_t;

endpackage

`default_nettype wire

### hdl/rbd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module rbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // rdata holds between reads so a stalled result keeps its word
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/rbd_ctrl.sv
// Index and count keeper for the ring buffer deque: decides each operation,
// picks the slot address and steps front, rear and count.
// Depends on rbd_pkg.
`default_nettype none

module rbd_ctrl #(
  parameter int DEPTH = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      issue,
  input  wire logic [1:0]                func,
  input  wire logic [rbd_pkg::CAP_W-1:0] capacity,
  output logic                           mem_we,
  output logic                           mem_re,
  output logic      [$clog2(DEPTH)-1:0]  mem_addr,
  output rbd_pkg::result_t               res
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = ((IDX_W > rbd_pkg::CAP_W) ? IDX_W : rbd_pkg::CAP_W) + 1;

  logic [IDX_W-1:0]            front, front_next;
  logic [IDX_W-1:0]            rear, rear_next;
  logic [rbd_pkg::COUNT_W-1:0] count, count_next;

  logic [CMP_W-1:0] cap_eff;
  logic [IDX_W-1:0] front_fwd, front_back, rear_fwd, rear_back;
  logic             full, empty, ok;
  rbd_pkg::func_t   op;

  assign op = rbd_pkg::func_t'(func);

  // capacity 0 acts as 1, anything above DEPTH acts as DEPTH
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end else begin
      cap_eff = CMP_W'(capacity);
    end
  end

  assign front_fwd  = (CMP_W'(front) + CMP_W'(1) >= cap_eff) ? '0 : front + IDX_W'(1);
  assign rear_fwd   = (CMP_W'(rear) + CMP_W'(1) >= cap_eff) ? '0 : rear + IDX_W'(1);
  assign front_back = (front == '0) ? IDX_W'(cap_eff - CMP_W'(1)) : front - IDX_W'(1);
  assign rear_back  = (rear == '0) ? IDX_W'(cap_eff - CMP_W'(1)) : rear - IDX_W'(1);

  assign full  = CMP_W'(count) >= cap_eff;
  assign empty = (count == '0);

  always_comb begin
    front_next = front;
    rear_next  = rear;
    count_next = count;
    mem_addr   = front;
    ok         = 1'b0;
    res.status = rbd_pkg::STATUS_DONE;
    unique case (op)
      rbd_pkg::FUNC_PUSH_FRONT: begin
        mem_addr = front_back;
        if (full) begin
          res.status = rbd_pkg::STATUS_FULL;
        end else begin
          ok         = 1'b1;
          front_next = front_back;
          count_next = count + rbd_pkg::COUNT_W'(1);
        end
      end
      rbd_pkg::FUNC_PUSH_REAR: begin
        mem_addr = rear;
        if (full) begin
          res.status = rbd_pkg::STATUS_FULL;
        end else begin
          ok         = 1'b1;
          rear_next  = rear_fwd;
          count_next = count + rbd_pkg::COUNT_W'(1);
        end
      end
      rbd_pkg::FUNC_POP_FRONT: begin
        mem_addr = front;
        if (empty) begin
          res.status = rbd_pkg::STATUS_EMPTY;
        end else begin
          ok         = 1'b1;
          front_next = front_fwd;
          count_next = count - rbd_pkg::COUNT_W'(1);
        end
      end
      rbd_pkg::FUNC_POP_REAR: begin
        mem_addr = rear_back;
        if (empty) begin
          res.status = rbd_pkg::STATUS_EMPTY;
        end else begin
          ok         = 1'b1;
          rear_next  = rear_back;
          count_next = count - rbd_pkg::COUNT_W'(1);
        end
      end
      default: begin
        mem_addr = front;
      end
    endcase
    res.count  = count_next;
    res.empty  = (count_next == '0);
    res.pop_ok = ok && func[1];
  end

  // func[1] set means a pop
  assign mem_we = issue && ok && !func[1];
  assign mem_re = issue && ok && func[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      rear  <= '0;
      count <= '0;
    end else if (issue) begin
      front <= front_next;
      rear  <= rear_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

### hdl/ring_buffer_deque.sv
// Ring buffer deque top level: capacity register, issue stage, slot RAM and
// output register.
// Depends on rbd_pkg, rbd_ctrl and rbd_ram.
// Usage:
//   Input channel (in_valid/in_stall) carries one word: func and push_value.
//   func selects push front, push rear, pop front or pop rear.
//   Output channel (out_valid/out_stall) returns one word per input word:
//   status, popped_value (zero unless a pop succeeded), element_count and
//   is_empty, in input order.
//   Configuration channel (cfg_valid/cfg_ready) writes capacity_in_use; it is
//   always ready and must only be written while the block is idle.
//   An accepted word passes the issue stage, which issues the operation and
//   reads the slot RAM, and then the output register.
//   Throughput is one word per cycle while the output is not stalled; front,
//   rear and count update at issue, so back-to-back operations see each other,
//   and a slot written by a push is in the RAM before the next cycle's read.
//   A stalled output holds its word; the issue stage keeps one more word,
//   after which in_stall rises until the output drains.
//   Reset (rst, synchronous) empties the deque and sets the capacity to 16.
//   Slot contents are not cleared.
`default_nettype none

module ring_buffer_deque #(
  parameter int DEPTH     = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    func,
  input  wire logic signed [WORD_BITS-1:0]   push_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [1:0]                    status,
  output logic signed [WORD_BITS-1:0]        popped_value,
  output logic      [rbd_pkg::COUNT_W-1:0]   element_count,
  output logic                               is_empty,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rbd_pkg::CAP_W-1:0]     cfg_data
);

  logic [rbd_pkg::CAP_W-1:0] capacity;
  logic                      accept, advance;
  logic                      mem_we, mem_re;
  logic [$clog2(DEPTH)-1:0]  mem_addr;
  logic [WORD_BITS-1:0]      rdata;
  rbd_pkg::result_t          res;
  rbd_pkg::result_t          s1_res;
  logic                      s1_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= rbd_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  rbd_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .issue   (accept),
    .func    (func),
    .capacity(capacity),
    .mem_we  (mem_we),
    .mem_re  (mem_re),
    .mem_addr(mem_addr),
    .res     (res)
  );

  rbd_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_addr),
    .wdata($unsigned(push_value)),
    .re   (mem_re),
    .raddr(mem_addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status        <= s1_res.status;
      popped_value  <= s1_res.pop_ok ? $signed(rdata) : '0;
      element_count <= s1_res.count;
      is_empty      <= s1_res.empty;
    end
  end

endmodule

`default_nettype wire
